// ----- hdl/orot_pkg.sv -----
// ----------------------------------------------------------------------------
// Oriented rectangle overlap test - shared definitions
// Widths, corner-store geometry, sequencer states and the vector type used by
// the dot-product unit.
// ----------------------------------------------------------------------------
package orot_pkg;

	// Corner coordinate width, signed with 4 fraction bits.
	localparam int COORD_BITS = 16;
	// A difference of two coordinates needs one more bit.
	localparam int DIFF_BITS  = COORD_BITS + 1;
	// One exact product of two differences.
	localparam int PROD_BITS  = 2 * DIFF_BITS;
	// Sum of two products (dot product or squared edge length).
	localparam int SUM_BITS   = PROD_BITS + 1;

	// Corner store: two rectangles of four corners, x in the low half.
	localparam int NUM_CORNERS = 8;
	localparam int ADDR_BITS   = $clog2(NUM_CORNERS);
	localparam int ENTRY_BITS  = 2 * COORD_BITS;

	// Corner numbers that, with corner 0, define the two tested edges.
	localparam logic [1:0] CORNER_ORIGIN = 2'd0;
	localparam logic [1:0] CORNER_EDGE_E = 2'd1;
	localparam logic [1:0] CORNER_EDGE_F = 2'd3;
	localparam logic [1:0] CORNER_LAST   = 2'd3;
	localparam logic [1:0] AXIS_LAST     = 2'd3;

	typedef struct packed {
		logic signed [DIFF_BITS-1:0] x;
		logic signed [DIFF_BITS-1:0] y;
	} dvec_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ORG_RD,
		S_ORG_CAP,
		S_EDGE_MUL,
		S_EDGE_ADD,
		S_PT_MUL,
		S_PT_ADD,
		S_CHECK
	} state_t;

endpackage

// ----- hdl/orot_corner_if.sv -----
// ----------------------------------------------------------------------------
// Corner channel
// Valid/ready channel that carries one rectangle corner per transaction.
// ----------------------------------------------------------------------------
interface orot_corner_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  box;
	logic [1:0]                            corner_index;
	logic signed [orot_pkg::COORD_BITS-1:0] x;
	logic signed [orot_pkg::COORD_BITS-1:0] y;
	logic                                  evaluate;

	modport source (output valid, box, corner_index, x, y, evaluate, input ready);
	modport sink   (input valid, box, corner_index, x, y, evaluate, output ready);
endinterface

// ----- hdl/orot_result_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one overlap verdict per transaction.
// ----------------------------------------------------------------------------
interface orot_result_if;
	logic valid;
	logic ready;
	logic overlap;

	modport source (output valid, overlap, input ready);
	modport sink   (input valid, overlap, output ready);
endinterface

// ----- hdl/orot_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module orot_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/orot_dot.sv -----
// ----------------------------------------------------------------------------
// Dot-product unit
// Two signed multipliers with registered products, summed on the way out.
// ----------------------------------------------------------------------------
module orot_dot (
	input  logic                                clk,
	input  orot_pkg::dvec_t                     u,
	input  orot_pkg::dvec_t                     v,
	output logic signed [orot_pkg::SUM_BITS-1:0] sum
);

	logic signed [orot_pkg::PROD_BITS-1:0] px_s1;
	logic signed [orot_pkg::PROD_BITS-1:0] py_s1;

	// The products are free running; the sum is valid in the cycle after u and v.
	always_ff @(posedge clk) begin
		px_s1 <= u.x * v.x;
		py_s1 <= u.y * v.y;
	end

	assign sum = orot_pkg::SUM_BITS'(px_s1) + orot_pkg::SUM_BITS'(py_s1);

endmodule

// ----- hdl/oriented_rect_overlap_test.sv -----
// ----------------------------------------------------------------------------
// Oriented rectangle overlap test
// Separating-axis test for two oriented rectangles loaded corner by corner.
// ----------------------------------------------------------------------------
// Usage:
// The corner channel takes one corner per transaction: box selects the first
// or second rectangle, corner_index the corner in perimeter order, and x and y
// are signed coordinates with 4 fraction bits. A transaction with evaluate
// set stores its corner and then starts the test; the corner channel stays
// not ready until the test is done. The overlap verdict then appears on the
// result channel. All steps share the single dot-product unit: for each of
// the four axes the sequencer reads the axis origin, forms the edge vector
// and its squared length, projects the four corners of the other rectangle
// and compares the projections against the edge.
// The verdict sits in an output register; while the receiver stalls, new
// corners are still taken, and a new evaluation waits in its final compare
// step until the previous verdict has been taken.
// Reset clears the sequencer and the result valid flag. The corner store is not
// cleared: every corner must be written before the first evaluation.
// ----------------------------------------------------------------------------
module oriented_rect_overlap_test (
	input  logic                clk,
	input  logic                arst_n,
	orot_corner_if.sink         corner,
	orot_result_if.source       result
);

	localparam int CB = orot_pkg::COORD_BITS;
	localparam int SW = orot_pkg::SUM_BITS;

	orot_pkg::state_t state_q, state_d;

	logic [1:0] axis_q;     // bit 1: rectangle owning the axis, bit 0: which edge
	logic [1:0] pt_q;       // corner of the other rectangle being projected
	logic       sep_q;      // some axis tested so far separates
	logic       out_valid_q;
	logic       overlap_q;

	logic signed [CB-1:0] ox_q, oy_q;   // corner 0 of the axis rectangle
	orot_pkg::dvec_t      a_q;          // axis vector
	logic signed [SW-1:0] len2_q;       // squared axis length
	logic signed [SW-1:0] tmin_q, tmax_q;

	logic                             corner_ready;
	logic                             corner_acc;
	logic                             load_res;
	logic [orot_pkg::ADDR_BITS-1:0]   rd_addr;
	logic [orot_pkg::ENTRY_BITS-1:0]  rd_data;
	logic [1:0]                       axis_next;
	logic [1:0]                       edge_corner;
	logic                             own_box;
	logic                             other_box;
	logic signed [CB-1:0]             px, py;
	orot_pkg::dvec_t                  diff;
	orot_pkg::dvec_t                  dot_v;
	logic signed [SW-1:0]             dot_sum;
	logic                             sep_now;

	assign corner_acc = corner.valid && corner_ready;
	assign corner.ready = corner_ready;

	// Corner store: address is {box, corner}, entry is {y, x}.
	orot_ram #(
		.WIDTH(orot_pkg::ENTRY_BITS),
		.DEPTH(orot_pkg::NUM_CORNERS)
	) u_store (
		.clk   (clk),
		.we    (corner_acc),
		.waddr ({corner.box, corner.corner_index}),
		.wdata ({corner.y, corner.x}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Every corner read by the sequencer is taken relative to the axis origin,
	// so one subtractor serves the edge vector and all the projections.
	assign px = rd_data[CB-1:0];
	assign py = rd_data[2*CB-1:CB];
	assign diff.x = {px[CB-1], px} - {ox_q[CB-1], ox_q};
	assign diff.y = {py[CB-1], py} - {oy_q[CB-1], oy_q};

	// The edge cycle squares the edge vector; every other cycle projects onto it.
	assign dot_v = (state_q == orot_pkg::S_EDGE_MUL) ? diff : a_q;

	orot_dot u_dot (
		.clk (clk),
		.u   (diff),
		.v   (dot_v),
		.sum (dot_sum)
	);

	assign own_box     = axis_q[1];
	assign other_box   = ~axis_q[1];
	assign edge_corner = axis_q[0] ? orot_pkg::CORNER_EDGE_F : orot_pkg::CORNER_EDGE_E;
	assign axis_next   = axis_q + 2'd1;

	// An axis separates when all projections lie beyond the far end of the edge
	// or all lie before its origin. Touching is not a separation.
	assign sep_now = (tmin_q > len2_q) || tmax_q[SW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= orot_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		rd_addr      = {own_box, orot_pkg::CORNER_ORIGIN};
		corner_ready = 1'b0;
		load_res     = 1'b0;
		case (state_q)
			orot_pkg::S_IDLE: begin
				corner_ready = 1'b1;
				if (corner.valid && corner.evaluate) begin
					state_d = orot_pkg::S_ORG_RD;
				end
			end
			orot_pkg::S_ORG_RD: begin
				rd_addr = {own_box, orot_pkg::CORNER_ORIGIN};
				state_d = orot_pkg::S_ORG_CAP;
			end
			orot_pkg::S_ORG_CAP: begin
				rd_addr = {own_box, edge_corner};
				state_d = orot_pkg::S_EDGE_MUL;
			end
			orot_pkg::S_EDGE_MUL: begin
				state_d = orot_pkg::S_EDGE_ADD;
			end
			orot_pkg::S_EDGE_ADD: begin
				rd_addr = {other_box, pt_q};
				state_d = orot_pkg::S_PT_MUL;
			end
			orot_pkg::S_PT_MUL: begin
				state_d = orot_pkg::S_PT_ADD;
			end
			orot_pkg::S_PT_ADD: begin
				if (pt_q == orot_pkg::CORNER_LAST) begin
					state_d = orot_pkg::S_CHECK;
				end else begin
					rd_addr = {other_box, pt_q + 2'd1};
					state_d = orot_pkg::S_PT_MUL;
				end
			end
			orot_pkg::S_CHECK: begin
				if (axis_q == orot_pkg::AXIS_LAST) begin
					if (!out_valid_q || result.ready) begin
						load_res = 1'b1;
						state_d  = orot_pkg::S_IDLE;
					end
				end else begin
					rd_addr = {axis_next[1], orot_pkg::CORNER_ORIGIN};
					state_d = orot_pkg::S_ORG_CAP;
				end
			end
			default: begin
				state_d = orot_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer counters and the accumulated verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q      <= '0;
			pt_q        <= '0;
			sep_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == orot_pkg::S_IDLE && corner_acc && corner.evaluate) begin
				axis_q <= '0;
				sep_q  <= 1'b0;
			end
			// The corner counter wraps to zero after the last corner of each axis.
			if (state_q == orot_pkg::S_PT_ADD) begin
				pt_q <= pt_q + 2'd1;
			end
			if (state_q == orot_pkg::S_CHECK) begin
				sep_q <= sep_q | sep_now;
				if (axis_q != orot_pkg::AXIS_LAST) begin
					axis_q <= axis_next;
				end
			end
			if (load_res) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == orot_pkg::S_ORG_CAP || state_q == orot_pkg::S_CHECK) begin
			ox_q <= px;
			oy_q <= py;
		end
		if (state_q == orot_pkg::S_EDGE_MUL) begin
			a_q <= diff;
		end
		if (state_q == orot_pkg::S_EDGE_ADD) begin
			len2_q <= dot_sum;
		end
		if (state_q == orot_pkg::S_PT_ADD) begin
			if (pt_q == orot_pkg::CORNER_ORIGIN) begin
				tmin_q <= dot_sum;
				tmax_q <= dot_sum;
			end else begin
				if (dot_sum < tmin_q) begin
					tmin_q <= dot_sum;
				end
				if (dot_sum > tmax_q) begin
					tmax_q <= dot_sum;
				end
			end
		end
		if (load_res) begin
			overlap_q <= ~(sep_q | sep_now);
		end
	end

	assign result.valid   = out_valid_q;
	assign result.overlap = overlap_q;

endmodule

// ----- hdl/orot_checker.sv -----
// ----------------------------------------------------------------------------
// Oriented rectangle overlap test - port checker
// Watches the corner and result channels of the top level over time.
// ----------------------------------------------------------------------------
module orot_checker (
	input logic clk,
	input logic arst_n,
	input logic corner_valid,
	input logic corner_ready,
	input logic corner_evaluate,
	input logic result_valid,
	input logic result_ready,
	input logic result_overlap
);

	// A pending verdict stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result valid dropped while stalled");

	// A pending verdict does not change while stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_overlap))
		else $error("result overlap changed while stalled");

	// Starting an evaluation closes the corner channel in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		corner_valid && corner_ready && corner_evaluate |=> !corner_ready)
		else $error("corner channel open during an evaluation");

	// A plain corner load never produces a verdict.
	assert property (@(posedge clk) disable iff (!arst_n)
		corner_valid && corner_ready && !corner_evaluate && !result_valid
		|=> !result_valid)
		else $error("verdict produced by a corner load");

	// A new verdict only appears at the end of an evaluation.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!corner_ready))
		else $error("verdict appeared while the block was idle");

endmodule

bind oriented_rect_overlap_test orot_checker u_orot_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.corner_valid    (corner.valid),
	.corner_ready    (corner.ready),
	.corner_evaluate (corner.evaluate),
	.result_valid    (result.valid),
	.result_ready    (result.ready),
	.result_overlap  (result.overlap)
);

// ----- sim/tb_oriented_rect_overlap_test.sv -----
// ----------------------------------------------------------------------------
// Oriented rectangle overlap test - self-checking testbench
// Loads pairs of oriented rectangles corner by corner, keeps its own copy of
// the corner store, predicts every overlap verdict with exact separating-axis
// arithmetic and compares each verdict the block returns against it, under
// several mixes of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_oriented_rect_overlap_test;

	// Even if every corner evaluated and every verdict met the longest stall
	// and gap, a run of this size stays well below this bound.
	localparam int CYCLE_LIMIT  = 800000;
	// Cycles to keep watching after the last verdict, for stray results.
	localparam int FLUSH_CYCLES = 64;
	// Only the first REPORT_MAX mismatches are printed; later ones are only counted.
	localparam int REPORT_MAX   = 10;
	// Random corners per idling phase (four phases, about 1450 in all).
	localparam int PHASE_ITEMS  = 362;

	typedef logic signed [orot_pkg::COORD_BITS-1:0] coord_t;

	// One corner transaction as queued for the driver. The drain flag is a
	// testbench-only marker: the driver holds this corner back until every
	// outstanding verdict has come home.
	typedef struct {
		bit        box;
		logic [1:0] corner_index;
		coord_t    x;
		coord_t    y;
		bit        evaluate;
		bit        drain_first;
	} corner_item_t;

	typedef struct {
		coord_t x;
		coord_t y;
	} point_t;

	logic clk;
	logic arst_n;

	orot_corner_if corner_bus ();
	orot_result_if result_bus ();

	oriented_rect_overlap_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.corner (corner_bus),
		.result (result_bus)
	);

	// Corners waiting to be driven, and the verdicts the block still owes us.
	corner_item_t corner_backlog[$];
	bit           pending_verdicts[$];

	// Our own copy of the eight-entry corner store, updated on acceptance.
	point_t corner_model[orot_pkg::NUM_CORNERS];

	// Corners of the sequence being assembled before it is shuffled.
	corner_item_t rect_seq[$];

	// Which store entries the stimulus has written so far. An evaluation is
	// never requested until all eight have been loaded, since the block does
	// not clear its store on reset.
	logic [orot_pkg::NUM_CORNERS-1:0] loaded_mask;

	int  send_idle_pct;
	int  result_stall_pct;
	bit  drain_next;
	bit  corner_taken;
	int  corners_queued;
	int  corners_accepted;
	int  verdicts_checked;
	int  overlaps_seen;
	int  separations_seen;
	int  mismatch_count;
	int  cycle_count;
	int  pair_cx;
	int  pair_cy;

	corner_item_t drive_item;

	// ------------------------------------------------------------------------
	// Clock: period of 4 time units.
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Verdict predictor.
	// An axis of rectangle rb runs from its corner 0 towards corner
	// edge_corner. Every corner of rectangle ob is projected onto it relative
	// to corner 0. The axis separates when all projections lie beyond the
	// squared edge length or all lie below zero. The arithmetic is exact:
	// a 17-bit difference squared fits easily in 64 bits, so no division and
	// no rounding is involved. A zero-length axis projects everything to 0
	// against a length of 0 and so can never separate. Touching leaves a
	// projection equal to a bound, which also does not separate.
	// ------------------------------------------------------------------------
	function automatic bit axis_separates_corners(int rb, logic [1:0] edge_corner, int ob);
		longint ox, oy, ax, ay, len2, px, py, t, tmin, tmax;
		int     c;
		ox = corner_model[rb * 4 + orot_pkg::CORNER_ORIGIN].x;
		oy = corner_model[rb * 4 + orot_pkg::CORNER_ORIGIN].y;
		ax = longint'(corner_model[rb * 4 + edge_corner].x) - ox;
		ay = longint'(corner_model[rb * 4 + edge_corner].y) - oy;
		len2 = ax * ax + ay * ay;
		tmin = 0;
		tmax = 0;
		for (c = 0; c <= int'(orot_pkg::CORNER_LAST); c++) begin
			px = corner_model[ob * 4 + c].x;
			py = corner_model[ob * 4 + c].y;
			t = (px - ox) * ax + (py - oy) * ay;
			if (c == 0 || t < tmin) begin
				tmin = t;
			end
			if (c == 0 || t > tmax) begin
				tmax = t;
			end
		end
		return (tmin > len2) || (tmax < 0);
	endfunction

	// Both rectangles contribute two axes each; one separating axis from
	// either side is enough to declare the rectangles apart.
	function automatic bit rects_overlap();
		bit apart;
		apart = axis_separates_corners(0, orot_pkg::CORNER_EDGE_E, 1)
		     || axis_separates_corners(0, orot_pkg::CORNER_EDGE_F, 1)
		     || axis_separates_corners(1, orot_pkg::CORNER_EDGE_E, 0)
		     || axis_separates_corners(1, orot_pkg::CORNER_EDGE_F, 0);
		return !apart;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	function automatic corner_item_t make_corner(bit box, logic [1:0] ci, int x, int y,
	                                             bit evaluate);
		corner_item_t it;
		it.box          = box;
		it.corner_index = ci;
		it.x            = coord_t'(x);
		it.y            = coord_t'(y);
		it.evaluate     = evaluate;
		it.drain_first  = 1'b0;
		return it;
	endfunction

	// Hands one corner to the driver. The first corner after a drain request
	// carries the hold-back marker.
	task automatic queue_corner(corner_item_t it);
		it.drain_first = drain_next;
		drain_next = 1'b0;
		loaded_mask[{it.box, it.corner_index}] = 1'b1;
		if (!(&loaded_mask)) begin
			it.evaluate = 1'b0;
		end
		corner_backlog.push_back(it);
		corners_queued++;
	endtask

	// Builds a true rectangle around (cx, cy): edge e along a small integer
	// direction, edge f along its perpendicular, so that the corners are
	// exact. Either length may come out zero, which gives a degenerate shape.
	task automatic add_random_rect(bit box, int cx, int cy, bit wide);
		int dx, dy, l1, l2, ex, ey, fx, fy, ox, oy;
		dx = int'($urandom_range(8)) - 4;
		dy = int'($urandom_range(8)) - 4;
		l1 = int'($urandom_range(wide ? 2000 : 40));
		l2 = int'($urandom_range(wide ? 2000 : 40));
		ex = dx * l1;
		ey = dy * l1;
		fx = -dy * l2;
		fy = dx * l2;
		ox = cx - (ex + fx) / 2;
		oy = cy - (ey + fy) / 2;
		rect_seq.push_back(make_corner(box, 2'd0, ox, oy, 1'b0));
		rect_seq.push_back(make_corner(box, 2'd1, ox + ex, oy + ey, 1'b0));
		rect_seq.push_back(make_corner(box, 2'd2, ox + ex + fx, oy + ey + fy, 1'b0));
		rect_seq.push_back(make_corner(box, 2'd3, ox + fx, oy + fy, 1'b0));
	endtask

	// Loads the assembled corners in random order and asks for an evaluation
	// on the one at position eval_at (a negative position asks for none).
	task automatic flush_seq(int eval_at);
		int           i, j;
		corner_item_t tmp;
		for (i = rect_seq.size() - 1; i > 0; i--) begin
			j = int'($urandom_range(i));
			tmp = rect_seq[i];
			rect_seq[i] = rect_seq[j];
			rect_seq[j] = tmp;
		end
		for (i = 0; i < rect_seq.size(); i++) begin
			rect_seq[i].evaluate = (i == eval_at);
			queue_corner(rect_seq[i]);
		end
		rect_seq.delete();
	endtask

	// One idling phase of random traffic. Most of it is well-formed: a fresh
	// pair of rectangles placed close together, or one of the two moved, and
	// an evaluation once the last corner is in. The rest evaluates part way
	// through a reload, or is raw noise over the whole coordinate range.
	task automatic run_phase(int idle_pct, int stall_pct, int n_items, bit drain);
		int first, r, k, cnt, spread;
		bit wide;
		send_idle_pct    = idle_pct;
		result_stall_pct = stall_pct;
		drain_next       = drain;
		first            = corners_queued;
		while (corners_queued - first < n_items) begin
			r      = int'($urandom_range(99));
			wide   = ($urandom_range(19) == 0);
			spread = wide ? 4000 : 200;
			if (r < 55 || (r >= 85 && r < 92)) begin
				pair_cx = wide ? int'($urandom_range(6000)) - 3000
				               : int'($urandom_range(40000)) - 20000;
				pair_cy = wide ? int'($urandom_range(6000)) - 3000
				               : int'($urandom_range(40000)) - 20000;
				add_random_rect(1'b0, pair_cx, pair_cy, wide);
				add_random_rect(1'b1, pair_cx + int'($urandom_range(2 * spread)) - spread,
				                pair_cy + int'($urandom_range(2 * spread)) - spread, wide);
				// A broken sequence evaluates at a random position.
				flush_seq(r < 55 ? 7 : int'($urandom_range(7)));
			end else if (r < 85) begin
				add_random_rect(r < 75 ? 1'b1 : 1'b0,
				                pair_cx + int'($urandom_range(2 * spread)) - spread,
				                pair_cy + int'($urandom_range(2 * spread)) - spread, wide);
				flush_seq(3);
			end else begin
				cnt = int'($urandom_range(1, 6));
				for (k = 0; k < cnt; k++) begin
					queue_corner(make_corner(1'($urandom_range(1)), 2'($urandom_range(3)),
					                         int'($urandom), int'($urandom),
					                         $urandom_range(3) == 0));
				end
			end
		end
		while (corners_accepted != corners_queued) begin
			@(posedge clk);
		end
	endtask

	task automatic flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			$display("ERROR: %s", msg);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver. Inputs change on the falling edge only. A corner stays on the
	// bus until a rising edge sees valid and ready together; only then, or
	// when the bus is empty, is a new corner (or a gap) chosen. The receiver
	// side draws a fresh ready every cycle.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (!arst_n) begin
			corner_bus.valid  <= 1'b0;
			result_bus.ready  <= 1'b0;
		end else begin
			result_bus.ready <= (int'($urandom_range(99)) >= result_stall_pct);
			if (!corner_bus.valid || corner_taken) begin
				if (corner_backlog.size() != 0
				    && !(corner_backlog[0].drain_first && pending_verdicts.size() != 0)
				    && int'($urandom_range(99)) >= send_idle_pct) begin
					drive_item = corner_backlog.pop_front();
					corner_bus.valid        <= 1'b1;
					corner_bus.box          <= drive_item.box;
					corner_bus.corner_index <= drive_item.corner_index;
					corner_bus.x            <= drive_item.x;
					corner_bus.y            <= drive_item.y;
					corner_bus.evaluate     <= drive_item.evaluate;
				end else begin
					corner_bus.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Everything is sampled on the rising edge. A verdict is checked
	// before a newly accepted evaluation queues its own expectation, so the
	// oldest expectation is always the one compared. An accepted corner
	// updates the model store first, then, if it asks for an evaluation, the
	// verdict is predicted from the store including that corner.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		corner_taken = 1'b0;
		if (arst_n) begin
			if (result_bus.valid && result_bus.ready) begin
				verdicts_checked++;
				if (result_bus.overlap) begin
					overlaps_seen++;
				end else begin
					separations_seen++;
				end
				if (pending_verdicts.size() == 0) begin
					flag_error($sformatf("verdict %0d arrived with none expected (overlap=%0b)",
					                     verdicts_checked, result_bus.overlap));
				end else if (pending_verdicts[0] !== result_bus.overlap) begin
					flag_error($sformatf("verdict %0d: overlap expected %0b, got %0b",
					                     verdicts_checked, pending_verdicts[0],
					                     result_bus.overlap));
					void'(pending_verdicts.pop_front());
				end else begin
					void'(pending_verdicts.pop_front());
				end
			end
			if (corner_bus.valid && corner_bus.ready) begin
				corner_taken = 1'b1;
				corners_accepted++;
				corner_model[{corner_bus.box, corner_bus.corner_index}] =
					'{corner_bus.x, corner_bus.y};
				if (corner_bus.evaluate) begin
					pending_verdicts.push_back(rects_overlap());
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: a hung handshake ends the run as a failure.
	// ------------------------------------------------------------------------
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("ERROR: no progress after %0d cycles", CYCLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	initial begin
		arst_n                  = 1'b0;
		corner_bus.valid        = 1'b0;
		corner_bus.box          = 1'b0;
		corner_bus.corner_index = 2'd0;
		corner_bus.x            = '0;
		corner_bus.y            = '0;
		corner_bus.evaluate     = 1'b0;
		result_bus.ready        = 1'b0;
		loaded_mask             = '0;
		send_idle_pct           = 0;
		result_stall_pct        = 0;
		drain_next              = 1'b0;
		corner_taken            = 1'b0;
		corners_queued          = 0;
		corners_accepted        = 0;
		verdicts_checked        = 0;
		overlaps_seen           = 0;
		separations_seen        = 0;
		mismatch_count          = 0;
		pair_cx                 = 0;
		pair_cy                 = 0;
		for (int i = 0; i < orot_pkg::NUM_CORNERS; i++) begin
			corner_model[i] = '{'0, '0};
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, no idling. Coordinates are in sixteenths.
		// Two 16 by 16 squares that share the edge x = 16: touching is overlap.
		queue_corner(make_corner(1'b0, 2'd0,   0,   0, 1'b0));
		queue_corner(make_corner(1'b0, 2'd1, 256,   0, 1'b0));
		queue_corner(make_corner(1'b0, 2'd2, 256, 256, 1'b0));
		queue_corner(make_corner(1'b0, 2'd3,   0, 256, 1'b0));
		queue_corner(make_corner(1'b1, 2'd0, 256,   0, 1'b0));
		queue_corner(make_corner(1'b1, 2'd1, 512,   0, 1'b0));
		queue_corner(make_corner(1'b1, 2'd2, 512, 256, 1'b0));
		queue_corner(make_corner(1'b1, 2'd3, 256, 256, 1'b1));
		// Pull the second square back by one LSB: now an axis separates.
		queue_corner(make_corner(1'b1, 2'd0, 257,   0, 1'b0));
		queue_corner(make_corner(1'b1, 2'd3, 257, 256, 1'b1));
		// Collapse the first rectangle to a point inside the second, so both
		// of its edges have zero length.
		queue_corner(make_corner(1'b0, 2'd0, 300, 100, 1'b0));
		queue_corner(make_corner(1'b0, 2'd1, 300, 100, 1'b0));
		queue_corner(make_corner(1'b0, 2'd2, 300, 100, 1'b0));
		queue_corner(make_corner(1'b0, 2'd3, 300, 100, 1'b1));
		// First rectangle spans the full coordinate range.
		queue_corner(make_corner(1'b0, 2'd0, -32768, -32768, 1'b0));
		queue_corner(make_corner(1'b0, 2'd1,  32767, -32768, 1'b0));
		queue_corner(make_corner(1'b0, 2'd2,  32767,  32767, 1'b0));
		queue_corner(make_corner(1'b0, 2'd3, -32768,  32767, 1'b1));
		// Second one as well, walked from the opposite corner, so that the
		// largest differences and products appear on both sides.
		queue_corner(make_corner(1'b1, 2'd0,  32767,  32767, 1'b0));
		queue_corner(make_corner(1'b1, 2'd1, -32768,  32767, 1'b0));
		queue_corner(make_corner(1'b1, 2'd2, -32768, -32768, 1'b0));
		queue_corner(make_corner(1'b1, 2'd3,  32767, -32768, 1'b1));
		// Reload corners 0 and 1 of the second rectangle along the top edge, against the full square.
		queue_corner(make_corner(1'b1, 2'd0, -32768,  32767, 1'b0));
		queue_corner(make_corner(1'b1, 2'd1,  32767,  32767, 1'b1));
		while (corners_accepted != corners_queued) begin
			@(posedge clk);
		end

		// Random part. Each later phase opens with the sender holding back
		// until every verdict so far has been returned.
		run_phase(0,  0,  PHASE_ITEMS, 1'b0);
		run_phase(60, 0,  PHASE_ITEMS, 1'b1);
		run_phase(0,  60, PHASE_ITEMS, 1'b1);
		run_phase(25, 25, PHASE_ITEMS, 1'b1);

		// Drain: take every verdict still owed, then keep watching for a
		// while so that a stray extra verdict would be seen.
		result_stall_pct = 0;
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			flag_error($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
		end

		$display("Summary: %0d corner transactions, %0d verdicts checked (%0d overlap, %0d apart)",
		         corners_accepted, verdicts_checked, overlaps_seen, separations_seen);
		$display("Summary: idle mixes none, sender, receiver and both; %0d mismatches in %0d cycles",
		         mismatch_count, cycle_count);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- oriented_rect_overlap_test.f -----
hdl/orot_pkg.sv
hdl/orot_corner_if.sv
hdl/orot_result_if.sv
hdl/orot_ram.sv
hdl/orot_dot.sv
hdl/oriented_rect_overlap_test.sv
hdl/orot_checker.sv
sim/tb_oriented_rect_overlap_test.sv
